// File: design/mt_pkg.sv
// Shared types, constants and word functions for the MT19937 generator.
package mt_pkg;

	localparam int unsigned STATE_WORDS   = 624;
	localparam int unsigned MIDDLE_OFFSET = 397;
	localparam int unsigned ADDR_W        = 10;

	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
	localparam logic [31:0] FILL_MULT    = 32'd1812433253;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [31:0] SEED_RESET   = 32'd5489;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [31:0]       word_t;

	// One write into both table copies.
	typedef struct packed {
		logic  we;
		addr_t addr;
		word_t data;
	} mem_wr_t;

	// Reads issued for one draw.
	typedef struct packed {
		logic  en;
		addr_t next_addr;
		addr_t mid_addr;
	} rd_req_t;

	// Queue entry: position and the two words fetched for it.
	typedef struct packed {
		addr_t addr;
		word_t next;
		word_t mid;
	} q_entry_t;

	localparam addr_t LAST_ADDR = addr_t'(STATE_WORDS - 1);

	function automatic addr_t wrap_inc(addr_t a);
		return (a == LAST_ADDR) ? '0 : a + addr_t'(1);
	endfunction

	function automatic addr_t mid_addr(addr_t a);
		logic [ADDR_W:0] s;
		s = {1'b0, a} + (ADDR_W+1)'(MIDDLE_OFFSET);
		if (s >= (ADDR_W+1)'(STATE_WORDS)) begin
			s = s - (ADDR_W+1)'(STATE_WORDS);
		end
		return s[ADDR_W-1:0];
	endfunction

	function automatic word_t fill_next(word_t w, addr_t k);
		word_t m;
		m = FILL_MULT * (w ^ (w >> 30));
		return m + word_t'(k);
	endfunction

	function automatic word_t twist(word_t here, word_t next, word_t mid);
		word_t mixed;
		mixed = (here & HIGH_BIT) | (next & LOW_BITS);
		return mid ^ (mixed >> 1) ^ (next[0] ? TWIST_MATRIX : '0);
	endfunction

	function automatic word_t temper(word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// File: design/mt_if.sv
// Valid/ready channel interfaces for draw requests and random words.
interface mt_req_if;
	logic valid;
	logic ready;
	logic draw;

	modport source(output valid, output draw, input ready);
	modport sink(input valid, input draw, output ready);
endinterface

interface mt_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

// File: design/mt_table.sv
// Two copies of the 624-word state table: one write, two reads per cycle.
module mt_table (
	input  logic            clk,
	input  mt_pkg::mem_wr_t fill_wr,
	input  mt_pkg::mem_wr_t twist_wr,
	input  mt_pkg::rd_req_t rd,
	output mt_pkg::word_t   rd_next,
	output mt_pkg::word_t   rd_mid
);
	import mt_pkg::*;

	word_t   mem_a [STATE_WORDS];
	word_t   mem_b [STATE_WORDS];
	mem_wr_t wr;
	word_t   next_q;
	word_t   mid_q;

	// fill and draws must not overlap, which is not enforced here; fill wins
	assign wr = fill_wr.we ? fill_wr : twist_wr;

	assign rd_next = next_q;
	assign rd_mid  = mid_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_a[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			next_q <= mem_a[rd.next_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_b[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			mid_q <= mem_b[rd.mid_addr];
		end
	end

endmodule

// File: design/mt_queue.sv
// Small FIFO between the fetch front and the twist/temper back.
module mt_queue #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mt_pkg::q_entry_t push_data,
	input  logic             pop,
	output logic             head_valid,
	output mt_pkg::q_entry_t head_data,
	output logic [CNT_W-1:0] count
);
	import mt_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	q_entry_t         entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: design/mt_front.sv
// Front: seed fill sequencer, draw acceptance, position and table reads.
module mt_front #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  mt_pkg::word_t     cfg_wdata,
	mt_req_if.sink            req,
	input  logic [CNT_W-1:0]  q_count,
	output mt_pkg::mem_wr_t   fill_wr,
	output mt_pkg::rd_req_t   rd,
	input  mt_pkg::word_t     rd_next,
	input  mt_pkg::word_t     rd_mid,
	output logic              push,
	output mt_pkg::q_entry_t  push_data
);
	import mt_pkg::*;

	localparam logic [CNT_W:0] DEPTH_C = (CNT_W+1)'(DEPTH);

	logic  fill_busy_q;
	addr_t fill_idx_q;
	word_t fill_word_q;
	addr_t pos_q;
	logic  valid_s1;
	addr_t addr_s1;
	logic  take;
	logic [CNT_W:0] in_flight;

	// entries already queued plus the one in the read stage
	assign in_flight = {1'b0, q_count} + (CNT_W+1)'(valid_s1);
	assign req.ready = !fill_busy_q && (in_flight < DEPTH_C);
	assign take      = req.valid && req.ready && req.draw;

	assign rd.en        = take;
	assign rd.next_addr = wrap_inc(pos_q);
	assign rd.mid_addr  = mid_addr(pos_q);

	assign fill_wr.we   = fill_busy_q;
	assign fill_wr.addr = fill_idx_q;
	assign fill_wr.data = fill_word_q;

	assign push           = valid_s1;
	assign push_data.addr = addr_s1;
	assign push_data.next = rd_next;
	assign push_data.mid  = rd_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_busy_q <= 1'b1;
			fill_idx_q  <= '0;
			fill_word_q <= SEED_RESET;
			pos_q       <= '0;
			valid_s1    <= 1'b0;
			addr_s1     <= '0;
		end else begin
			valid_s1 <= take;
			if (take) begin
				addr_s1 <= pos_q;
				pos_q   <= wrap_inc(pos_q);
			end
			if (cfg_we) begin
				fill_busy_q <= 1'b1;
				fill_idx_q  <= '0;
				fill_word_q <= cfg_wdata;
				pos_q       <= '0;
			end else if (fill_busy_q) begin
				fill_word_q <= fill_next(fill_word_q, wrap_inc(fill_idx_q));
				fill_idx_q  <= wrap_inc(fill_idx_q);
				if (fill_idx_q == LAST_ADDR) begin
					fill_busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: design/mt_back.sv
// Back: twist, table write-back, tempering and the output register.
module mt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mt_pkg::mem_wr_t  fill_wr,
	input  logic             head_valid,
	input  mt_pkg::q_entry_t head_data,
	output logic             pop,
	output mt_pkg::mem_wr_t  twist_wr,
	mt_rsp_if.source         rsp
);
	import mt_pkg::*;

	word_t here_q;
	word_t value_q;
	logic  out_valid_q;
	word_t fresh;

	// word at the current position is the previous draw's neighbor word
	assign fresh = twist(here_q, head_data.next, head_data.mid);
	assign pop   = head_valid && (!out_valid_q || rsp.ready);

	assign twist_wr.we   = pop;
	assign twist_wr.addr = head_data.addr;
	assign twist_wr.data = fresh;

	assign rsp.valid = out_valid_q;
	assign rsp.value = value_q;

	always_ff @(posedge clk) begin
		if (fill_wr.we && fill_wr.addr == '0) begin
			here_q <= fill_wr.data;
		end else if (pop) begin
			here_q <= head_data.next;
		end
		if (pop) begin
			value_q <= temper(fresh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: design/mersenne_twister_generator.sv
// Top level of the MT19937 generator: front, queue, table and back.
//
//   channel   dir  transfer when        payload
//   req       in   req.valid&req.ready  draw  (1 bit, draw low = no result)
//   rsp       out  rsp.valid&rsp.ready  value (32-bit tempered word)
//   cfg       in   cfg_we               cfg_wdata (seed)
//
// One draw per cycle sustained while rsp is not stalled and no fill runs;
// a result passes the table read, queue and output register in that order.
// Reset and every seed write run a fill of all 624 table words, one word per
// cycle through the seed multiplier; req.ready is low while it runs.
// A stalled rsp holds its word; the queue keeps taking requests until it
// and the read stage are full, then req.ready drops.
module mersenne_twister_generator #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  mt_pkg::word_t cfg_wdata,
	mt_req_if.sink        req,
	mt_rsp_if.source      rsp
);
	import mt_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	mem_wr_t          fill_wr;
	mem_wr_t          twist_wr;
	rd_req_t          rd;
	word_t            rd_next;
	word_t            rd_mid;
	logic             push;
	q_entry_t         push_data;
	logic             pop;
	logic             head_valid;
	q_entry_t         head_data;
	logic [CNT_W-1:0] q_count;

	// Front issues both reads at the request transfer; data lands in the next
	// cycle and is pushed into the queue with its position.
	mt_front #(.DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_count   (q_count),
		.fill_wr   (fill_wr),
		.rd        (rd),
		.rd_next   (rd_next),
		.rd_mid    (rd_mid),
		.push      (push),
		.push_data (push_data)
	);

	// Two table copies give the neighbor and the middle word each cycle.
	// The middle word of a late position was rewritten 227 draws back, far
	// more than the queue can hold, so reads never see a stale word.
	mt_table u_table (
		.clk      (clk),
		.fill_wr  (fill_wr),
		.twist_wr (twist_wr),
		.rd       (rd),
		.rd_next  (rd_next),
		.rd_mid   (rd_mid)
	);

	mt_queue #(.DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data),
		.count      (q_count)
	);

	// Back twists, writes the new word, tempers it into the output register.
	mt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fill_wr    (fill_wr),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.twist_wr   (twist_wr),
		.rsp        (rsp)
	);

endmodule

// File: design/mt_checker.sv
// Port-level checks for the MT19937 generator, bound to the top level.
module mt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_value
);

	// a stalled word stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
		else $error("rsp word changed or dropped under stall");

	// a seed write starts the fill at once
	a_fill_start: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req_ready)
		else $error("draws taken right after seed write");

	// fill still busy at its last word
	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> ##624 !req_ready)
		else $error("fill ended early");

	// output register only empties through a transfer
	a_rsp_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(rsp_ready))
		else $error("rsp valid dropped without transfer");

endmodule

bind mersenne_twister_generator mt_checker u_mt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value)
);

// File: tb/mersenne_twister_generator_tb.sv
// Testbench for the MT19937 generator: random-paced draws checked against a software twister.
module mersenne_twister_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mt_pkg::*;

	// Cycles with no transfer and no seed write before the run is declared hung.
	// Covers a full table fill, the longest sender gap and the long
	// receiver hold-off, with a wide margin.
	localparam int unsigned HANG_LIMIT   = 4000;
	// Settle time after a drain before a seed write; draw-low items owe nothing
	// and never enter the pipe.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 150;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_we;
	word_t cfg_wdata;

	mt_req_if req_ch();
	mt_rsp_if rsp_ch();

	mersenne_twister_generator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Software twister: own copy of the word table and read position.
	// ------------------------------------------------------------------
	word_t       mt_words [0:STATE_WORDS-1];
	int unsigned mt_pos;

	// Words the block still owes us, oldest first.
	word_t expected_words[$];
	// Draw bits waiting to be offered on the request channel.
	bit    pending_draws[$];

	int unsigned errors = 0;

	// Seed fill: w[k] = 1812433253 * (w[k-1] ^ (w[k-1] >> 30)) + k, mod 2^32.
	function automatic void load_seed(word_t s);
		word_t prev;
		mt_words[0] = s;
		for (int k = 1; k < STATE_WORDS; k++) begin
			prev        = mt_words[k-1];
			mt_words[k] = FILL_MULT * (prev ^ (prev >> 30)) + word_t'(k);
		end
		mt_pos = 0;
	endfunction

	// Regenerate the word at the read position in place, advance, and return
	// it tempered.
	function automatic word_t next_random_word();
		word_t cur, nxt, mid, y;
		cur = mt_words[mt_pos];
		nxt = mt_words[(mt_pos + 1) % STATE_WORDS];
		mid = mt_words[(mt_pos + MIDDLE_OFFSET) % STATE_WORDS];
		// top bit of cur joined to low 31 bits of nxt, shifted down by one
		y = mid ^ {1'b0, cur[31], nxt[30:1]} ^ (nxt[0] ? TWIST_MATRIX : word_t'(0));
		mt_words[mt_pos] = y;
		mt_pos = (mt_pos + 1) % STATE_WORDS;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		errors++;
		$display("%0t MISMATCH %s: got %08h expected %08h", $realtime, what, got, want);
	endtask

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int unsigned pick_idle(bit enabled);
		int unsigned r;
		if (!enabled) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Pacing controls, set per phase by the sequence below.
	// ------------------------------------------------------------------
	bit          src_gaps_on   = 1'b0;
	bit          sink_stalls_on = 1'b0;
	int unsigned hold_request  = 0;

	// ------------------------------------------------------------------
	// Request side. The posedge block sees the transfer and predicts;
	// the negedge block moves to the next item.
	// ------------------------------------------------------------------
	bit          req_fire = 1'b0;
	int unsigned gap_left = 0;
	logic        req_valid_nx;
	logic        req_draw_nx;

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			req_fire = 1'b1;
			// draw low is a legal transfer that owes nothing
			if (req_ch.draw) begin
				expected_words.push_back(next_random_word());
			end
		end
	end

	always @(negedge clk) begin
		req_valid_nx = req_ch.valid;
		req_draw_nx  = req_ch.draw;
		if (!arst_n) begin
			req_valid_nx = 1'b0;
			req_draw_nx  = 1'b0;
			gap_left     = 0;
		end else begin
			if (req_fire) begin
				req_valid_nx = 1'b0;
				req_fire     = 1'b0;
			end
			if (!req_valid_nx) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_draws.size() > 0) begin
					req_draw_nx  = pending_draws.pop_front();
					req_valid_nx = 1'b1;
					gap_left     = pick_idle(src_gaps_on);
				end
			end
		end
		// one update per signal per edge, so back-to-back items keep valid high
		req_ch.valid <= req_valid_nx;
		req_ch.draw  <= req_draw_nx;
	end

	// ------------------------------------------------------------------
	// Result side: ready pacing, including the long hold-off that lets the
	// internal queue fill and push back on requests.
	// ------------------------------------------------------------------
	int unsigned hold_left  = 0;
	int unsigned stall_left = 0;
	logic        rsp_ready_nx;

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready_nx = 1'b0;
		end else if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
			rsp_ready_nx = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ready_nx = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready_nx = 1'b0;
		end else begin
			stall_left   = pick_idle(sink_stalls_on);
			rsp_ready_nx = (stall_left == 0);
		end
		rsp_ch.ready <= rsp_ready_nx;
	end

	// Every result transfer is matched against the oldest owed word.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", rsp_ch.value, '0);
			end else begin
				word_t want;
				want = expected_words.pop_front();
				if (rsp_ch.value !== want) begin
					report_mismatch("value", rsp_ch.value, want);
				end
			end
		end
	end

	// Hang detector: any transfer or seed write counts as progress.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("TIMEOUT after %0d quiet cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	// Seed write while idle; the model reloads in step with the block, which
	// then spends its fill time with req.ready low.
	task automatic write_seed(word_t s);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= s;
		load_seed(s);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// n real draws with draw-low noise mixed in at about noise_pct percent.
	task automatic queue_draws(int unsigned n, int unsigned noise_pct);
		for (int unsigned i = 0; i < n; i++) begin
			while ($urandom_range(0, 99) < noise_pct) begin
				pending_draws.push_back(1'b0);
			end
			pending_draws.push_back(1'b1);
		end
	endtask

	// Wait until every item is offered and every owed word has arrived,
	// then wait out the settle time before the next step.
	task automatic drain();
		while (pending_draws.size() > 0 || req_ch.valid || expected_words.size() > 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		req_ch.valid = 1'b0;
		req_ch.draw  = 1'b0;
		rsp_ch.ready = 1'b0;
		load_seed(SEED_RESET);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: default seed after reset (first word 3499211612), draw-low
		// items alone and back to back, then the seed extremes.
		pending_draws.push_back(1'b1);
		pending_draws.push_back(1'b1);
		pending_draws.push_back(1'b0);
		pending_draws.push_back(1'b1);
		pending_draws.push_back(1'b0);
		pending_draws.push_back(1'b0);
		pending_draws.push_back(1'b1);
		pending_draws.push_back(1'b1);
		pending_draws.push_back(1'b1);
		drain();
		write_seed('0);
		queue_draws(6, 0);
		drain();
		write_seed('1);
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		queue_draws(6, 0);
		pending_draws.push_back(1'b0);
		drain();

		// Long phase: runs past the table end so the position wraps, and holds
		// the result side off long enough to back up the request side.
		write_seed(word_t'($urandom));
		queue_draws(700, 3);
		while (pending_draws.size() > 550) begin
			@(negedge clk);
		end
		hold_request = HOLD_CYCLES;
		drain();

		// Shorter phases with fresh seeds and mixed pacing.
		for (int ph = 0; ph < 3; ph++) begin
			src_gaps_on    = 1'($urandom_range(0, 1));
			sink_stalls_on = 1'($urandom_range(0, 1));
			write_seed(word_t'($urandom));
			queue_draws(180, 3);
			drain();
		end

		// Back to the reset seed with no idling at all.
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		write_seed(SEED_RESET);
		queue_draws(120, 2);
		drain();

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
design/mt_pkg.sv
design/mt_if.sv
design/mt_table.sv
design/mt_queue.sv
design/mt_front.sv
design/mt_back.sv
design/mersenne_twister_generator.sv
design/mt_checker.sv
tb/mersenne_twister_generator_tb.sv
